[design/button_debounce_click_long_press_defines.svh]
// Assertion macros used by the top-level design file.
`ifndef BUTTON_DEBOUNCE_CLICK_LONG_PRESS_DEFINES_SVH
`define BUTTON_DEBOUNCE_CLICK_LONG_PRESS_DEFINES_SVH

`ifndef SYNTHESIS
`define BDCL_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("same-cycle property failed");
`define BDCL_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle property failed");
`else
`define BDCL_ASSERT_SAME(label, clk, rst_n, ante, cons)
`define BDCL_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

[design/bdcl_pkg.sv]
package bdcl_pkg;

    localparam int TIME_W    = 32;
    localparam int CFG_W     = 16;
    localparam int CFG_IDX_W = 8;
    localparam int NUM_EV    = 7;
    localparam int CODE_W    = 3;
    localparam int Q_DEPTH   = 4;

    typedef enum logic [CODE_W-1:0] {
        EV_ENC_PRESS    = 3'd0,
        EV_ENC_RELEASE  = 3'd1,
        EV_ENC_CLICK    = 3'd2,
        EV_ENC_LONG     = 3'd3,
        EV_BACK_PRESS   = 3'd4,
        EV_BACK_RELEASE = 3'd5,
        EV_BACK_CLICK   = 3'd6
    } t_ev_code;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_DEBOUNCE   = 8'd0,
        REG_LONG_PRESS = 8'd1
    } t_reg_idx;

    localparam logic [CFG_W-1:0] DEBOUNCE_RST   = 16'd30;
    localparam logic [CFG_W-1:0] LONG_PRESS_RST = 16'd600;

    typedef struct packed {
        logic [CFG_W-1:0] debounce_ms;
        logic [CFG_W-1:0] long_press_ms;
    } t_cfg;

    // One poll's worth of events, bit i set means event code i occurred.
    typedef struct packed {
        logic [NUM_EV-1:0] mask;
        logic [TIME_W-1:0] time_ms;
        logic              held;
    } t_rec;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_status;

endpackage

[design/bdcl_ifs.sv]
interface bdcl_poll_if;
    logic        valid;
    logic        ready;
    logic [31:0] now_ms;
    logic        encoder_key_down;
    logic        back_key_down;

    modport source (output valid, now_ms, encoder_key_down, back_key_down, input ready);
    modport sink   (input valid, now_ms, encoder_key_down, back_key_down, output ready);
endinterface

interface bdcl_event_if;
    logic        valid;
    logic        ready;
    logic [2:0]  event_code;
    logic [31:0] event_time_ms;
    logic        encoder_held;
    logic        last_of_step;

    modport source (output valid, event_code, event_time_ms, encoder_held, last_of_step,
                    input ready);
    modport sink   (input valid, event_code, event_time_ms, encoder_held, last_of_step,
                    output ready);
endinterface

interface bdcl_cfg_if;
    logic        valid;
    logic        ready;
    logic [7:0]  index;
    logic [15:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

[design/bdcl_front.sv]
module bdcl_front (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  bdcl_pkg::t_cfg      i_cfg,
    bdcl_poll_if.sink           i_poll,
    input  bdcl_pkg::t_q_status i_q_status,
    output logic                o_push,
    output bdcl_pkg::t_rec      o_rec
);
    import bdcl_pkg::*;

    logic              r_enc_raw, n_enc_raw;
    logic              r_enc_stable, n_enc_stable;
    logic [TIME_W-1:0] r_enc_changed_at, n_enc_changed_at;
    logic [TIME_W-1:0] r_enc_pressed_at, n_enc_pressed_at;
    logic              r_enc_long_sent, n_enc_long_sent;
    logic              r_back_raw, n_back_raw;
    logic              r_back_stable, n_back_stable;
    logic [TIME_W-1:0] r_back_changed_at, n_back_changed_at;

    logic [TIME_W-1:0] now;
    logic [TIME_W-1:0] debounce_w;
    logic [TIME_W-1:0] long_w;
    logic              enc_flip;
    logic              back_flip;
    logic              accept;
    logic [NUM_EV-1:0] mask;

    assign now        = i_poll.now_ms;
    assign debounce_w = {{(TIME_W-CFG_W){1'b0}}, i_cfg.debounce_ms};
    assign long_w     = {{(TIME_W-CFG_W){1'b0}}, i_cfg.long_press_ms};
    assign i_poll.ready = !i_q_status.full;
    assign accept     = i_poll.valid && i_poll.ready;

    always_comb begin
        mask = '0;

        n_enc_raw        = i_poll.encoder_key_down;
        n_enc_changed_at = (i_poll.encoder_key_down != r_enc_raw) ? now : r_enc_changed_at;
        enc_flip = (n_enc_raw != r_enc_stable) && ((now - n_enc_changed_at) >= debounce_w);
        n_enc_stable     = enc_flip ? n_enc_raw : r_enc_stable;
        n_enc_pressed_at = r_enc_pressed_at;
        n_enc_long_sent  = r_enc_long_sent;
        if (enc_flip) begin
            n_enc_long_sent = 1'b0;
            if (n_enc_raw) begin
                n_enc_pressed_at   = now;
                mask[EV_ENC_PRESS] = 1'b1;
            end else begin
                mask[EV_ENC_RELEASE] = 1'b1;
                mask[EV_ENC_CLICK]   = !r_enc_long_sent;
            end
        end
        if (n_enc_stable && !n_enc_long_sent && ((now - n_enc_pressed_at) >= long_w)) begin
            n_enc_long_sent   = 1'b1;
            mask[EV_ENC_LONG] = 1'b1;
        end

        n_back_raw        = i_poll.back_key_down;
        n_back_changed_at = (i_poll.back_key_down != r_back_raw) ? now : r_back_changed_at;
        back_flip = (n_back_raw != r_back_stable) && ((now - n_back_changed_at) >= debounce_w);
        n_back_stable     = back_flip ? n_back_raw : r_back_stable;
        if (back_flip) begin
            if (n_back_raw) begin
                mask[EV_BACK_PRESS] = 1'b1;
            end else begin
                mask[EV_BACK_RELEASE] = 1'b1;
                mask[EV_BACK_CLICK]   = 1'b1;
            end
        end
    end

    // Every event of a poll sees the encoder state left after the encoder key was handled.
    assign o_rec.mask    = mask;
    assign o_rec.time_ms = now;
    assign o_rec.held    = n_enc_stable;
    assign o_push        = accept && (mask != '0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_enc_raw         <= 1'b0;
            r_enc_stable      <= 1'b0;
            r_enc_changed_at  <= '0;
            r_enc_pressed_at  <= '0;
            r_enc_long_sent   <= 1'b0;
            r_back_raw        <= 1'b0;
            r_back_stable     <= 1'b0;
            r_back_changed_at <= '0;
        end else if (accept) begin
            r_enc_raw         <= n_enc_raw;
            r_enc_stable      <= n_enc_stable;
            r_enc_changed_at  <= n_enc_changed_at;
            r_enc_pressed_at  <= n_enc_pressed_at;
            r_enc_long_sent   <= n_enc_long_sent;
            r_back_raw        <= n_back_raw;
            r_back_stable     <= n_back_stable;
            r_back_changed_at <= n_back_changed_at;
        end
    end

endmodule

[design/bdcl_fifo.sv]
module bdcl_fifo #(
    parameter int DEPTH = bdcl_pkg::Q_DEPTH
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_push,
    input  bdcl_pkg::t_rec      i_rec,
    input  logic                i_pop,
    output bdcl_pkg::t_rec      o_head,
    output bdcl_pkg::t_q_status o_status
);
    import bdcl_pkg::*;

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    t_rec          r_mem [DEPTH];
    logic [AW-1:0] r_wr_ptr, n_wr_ptr;
    logic [AW-1:0] r_rd_ptr, n_rd_ptr;
    logic [CW-1:0] r_count, n_count;
    logic          do_push;
    logic          do_pop;

    assign o_status.full  = (r_count == CW'(DEPTH));
    assign o_status.empty = (r_count == '0);
    assign do_push = i_push && !o_status.full;
    assign do_pop  = i_pop && !o_status.empty;
    assign o_head  = r_mem[r_rd_ptr];

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (do_push) begin
            n_wr_ptr = (r_wr_ptr == AW'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (do_pop) begin
            n_rd_ptr = (r_rd_ptr == AW'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        if (do_push && !do_pop) begin
            n_count = r_count + 1'b1;
        end else if (do_pop && !do_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_rec;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

endmodule

[design/bdcl_back.sv]
module bdcl_back (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  bdcl_pkg::t_rec      i_head,
    input  bdcl_pkg::t_q_status i_q_status,
    output logic                o_pop,
    bdcl_event_if.source        o_event
);
    import bdcl_pkg::*;

    logic [NUM_EV-1:0] r_done, n_done;
    logic              r_valid;
    logic [CODE_W-1:0] r_code;
    logic [TIME_W-1:0] r_time;
    logic              r_held;
    logic              r_last;

    logic [NUM_EV-1:0] remaining;
    logic [NUM_EV-1:0] pick_bit;
    logic [CODE_W-1:0] pick_code;
    logic              pick_last;
    logic              can_load;
    logic              load;

    assign remaining = i_head.mask & ~r_done;
    assign can_load  = !r_valid || o_event.ready;
    assign load      = can_load && !i_q_status.empty;

    // Lowest pending code first, which matches the order events arise within a poll.
    always_comb begin
        pick_code = '0;
        for (int i = NUM_EV - 1; i >= 0; i--) begin
            if (remaining[i]) begin
                pick_code = CODE_W'(i);
            end
        end
        pick_bit  = NUM_EV'(1) << pick_code;
        pick_last = ((remaining & ~pick_bit) == '0);
    end

    assign o_pop = load && pick_last;

    always_comb begin
        n_done = r_done;
        if (load) begin
            n_done = pick_last ? '0 : (r_done | pick_bit);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_done  <= '0;
        end else begin
            r_done <= n_done;
            if (load) begin
                r_valid <= 1'b1;
            end else if (can_load) begin
                r_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_code <= pick_code;
            r_time <= i_head.time_ms;
            r_held <= i_head.held;
            r_last <= pick_last;
        end
    end

    assign o_event.valid         = r_valid;
    assign o_event.event_code    = r_code;
    assign o_event.event_time_ms = r_time;
    assign o_event.encoder_held  = r_held;
    assign o_event.last_of_step  = r_last;

endmodule

[design/button_debounce_click_long_press.sv]
// Two-key debouncer: an encoder key with press, release, click and long-press events and a
// back key with press, release and click events. A poll is taken whenever the event queue
// (QDEPTH polls deep) has room; polls that cause no event never enter it. The output
// register sends one event per cycle while the receiver is ready, so the output side sets
// the sustained rate; a poll causes at most four events. Configuration writes are taken
// every cycle and are meant for an idle block.
`include "button_debounce_click_long_press_defines.svh"

module button_debounce_click_long_press #(
    parameter int QDEPTH = bdcl_pkg::Q_DEPTH
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    bdcl_poll_if.sink    i_poll,
    bdcl_cfg_if.sink     i_cfg,
    bdcl_event_if.source o_event
);
    import bdcl_pkg::*;

    logic [CFG_W-1:0] r_debounce_ms;
    logic [CFG_W-1:0] r_long_press_ms;
    t_cfg             cfg;
    t_rec             push_rec;
    t_rec             head_rec;
    t_q_status        q_status;
    logic             push;
    logic             pop;
    logic             ev_take;
    logic             ev_back_rel;
    logic             ev_back_click;
    logic             ev_enc_down;
    logic             ev_enc_up;

    assign i_cfg.ready       = 1'b1;
    assign cfg.debounce_ms   = r_debounce_ms;
    assign cfg.long_press_ms = r_long_press_ms;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_debounce_ms   <= DEBOUNCE_RST;
            r_long_press_ms <= LONG_PRESS_RST;
        end else if (i_cfg.valid) begin
            case (i_cfg.index)
                REG_DEBOUNCE:   r_debounce_ms   <= i_cfg.data;
                REG_LONG_PRESS: r_long_press_ms <= i_cfg.data;
                default: ;
            endcase
        end
    end

    bdcl_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg      (cfg),
        .i_poll     (i_poll),
        .i_q_status (q_status),
        .o_push     (push),
        .o_rec      (push_rec)
    );

    bdcl_fifo #(
        .DEPTH (QDEPTH)
    ) u_fifo (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .i_rec    (push_rec),
        .i_pop    (pop),
        .o_head   (head_rec),
        .o_status (q_status)
    );

    bdcl_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_head     (head_rec),
        .i_q_status (q_status),
        .o_pop      (pop),
        .o_event    (o_event)
    );

    assign ev_take       = o_event.valid && o_event.ready;
    assign ev_back_rel   = (o_event.event_code == EV_BACK_RELEASE);
    assign ev_back_click = o_event.valid && (o_event.event_code == EV_BACK_CLICK);
    assign ev_enc_down   = o_event.valid && ((o_event.event_code == EV_ENC_PRESS) ||
                                             (o_event.event_code == EV_ENC_LONG));
    assign ev_enc_up     = o_event.valid && ((o_event.event_code == EV_ENC_RELEASE) ||
                                             (o_event.event_code == EV_ENC_CLICK));

    // The rest of a poll's events are already queued, so they follow without a gap.
    `BDCL_ASSERT_NEXT(a_step_no_gap, i_clk, i_rst_n, ev_take && !o_event.last_of_step, o_event.valid)
    `BDCL_ASSERT_NEXT(a_back_click_follows, i_clk, i_rst_n, ev_take && ev_back_rel, ev_back_click)
    `BDCL_ASSERT_SAME(a_held_on_press, i_clk, i_rst_n, ev_enc_down, o_event.encoder_held)
    `BDCL_ASSERT_SAME(a_released_on_release, i_clk, i_rst_n, ev_enc_up, !o_event.encoder_held)

endmodule

[tb/sv/button_debounce_click_long_press_tb.sv]
`timescale 1ns / 100ps

module button_debounce_click_long_press_tb;
    import bdcl_pkg::*;

    localparam int CLK_HALF    = 10;
    localparam int RESET_TICKS = 9;
    localparam int SETTLE      = 24;
    localparam int CYCLE_LIMIT = 600000;
    localparam int PHASES      = 8;
    localparam int PHASE_POLLS = 48;

    // Register indexes that lie past the end of the register list.
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED_LO = 8'd2;
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED_HI = 8'd255;

    typedef struct {
        t_ev_code    code;
        logic [31:0] stamp;
        logic        held;
        logic        closes_poll;
    } t_key_event;

    class key_event_scoreboard;
        logic [15:0] debounce;
        logic [15:0] long_press;
        logic        enc_raw;
        logic        enc_level;
        logic [31:0] enc_since;
        logic [31:0] enc_down_at;
        logic        enc_long_done;
        logic        back_raw;
        logic        back_level;
        logic [31:0] back_since;
        t_key_event  pending[$];
        int          fails;
        int          events_seen;

        function new();
            debounce      = DEBOUNCE_RST;
            long_press    = LONG_PRESS_RST;
            enc_raw       = 1'b0;
            enc_level     = 1'b0;
            enc_since     = '0;
            enc_down_at   = '0;
            enc_long_done = 1'b0;
            back_raw      = 1'b0;
            back_level    = 1'b0;
            back_since    = '0;
            fails         = 0;
            events_seen   = 0;
        endfunction

        function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [15:0] val);
            if (idx == REG_DEBOUNCE) begin
                debounce = val;
            end else if (idx == REG_LONG_PRESS) begin
                long_press = val;
            end
        endfunction

        function void push_event(t_ev_code c, logic [31:0] t);
            t_key_event e;
            e.code        = c;
            e.stamp       = t;
            e.held        = enc_level;
            e.closes_poll = 1'b0;
            pending.push_back(e);
        endfunction

        function void note_poll(logic [31:0] now, logic enc_in, logic back_in);
            int first;
            first = pending.size();
            if (enc_in != enc_raw) begin
                enc_raw   = enc_in;
                enc_since = now;
            end
            if (enc_raw != enc_level && (now - enc_since) >= {16'd0, debounce}) begin
                enc_level = enc_raw;
                if (enc_level) begin
                    enc_down_at   = now;
                    enc_long_done = 1'b0;
                    push_event(EV_ENC_PRESS, now);
                end else begin
                    push_event(EV_ENC_RELEASE, now);
                    if (!enc_long_done) begin
                        push_event(EV_ENC_CLICK, now);
                    end
                    enc_long_done = 1'b0;
                end
            end
            if (enc_level && !enc_long_done && (now - enc_down_at) >= {16'd0, long_press}) begin
                enc_long_done = 1'b1;
                push_event(EV_ENC_LONG, now);
            end
            if (back_in != back_raw) begin
                back_raw   = back_in;
                back_since = now;
            end
            if (back_raw != back_level && (now - back_since) >= {16'd0, debounce}) begin
                back_level = back_raw;
                if (back_level) begin
                    push_event(EV_BACK_PRESS, now);
                end else begin
                    push_event(EV_BACK_RELEASE, now);
                    push_event(EV_BACK_CLICK, now);
                end
            end
            if (pending.size() > first) begin
                pending[$].closes_poll = 1'b1;
            end
        endfunction

        function void check_event(logic [2:0] code, logic [31:0] stamp, logic held,
                                  logic closes_poll);
            t_key_event e;
            events_seen++;
            if (pending.size() == 0) begin
                $error("unexpected event: event_code %0d, event_time_ms %0d", code, stamp);
                fails++;
                return;
            end
            e = pending.pop_front();
            if (code !== e.code) begin
                $error("event_code: expected %0d, got %0d", e.code, code);
                fails++;
            end
            if (stamp !== e.stamp) begin
                $error("event_time_ms: expected %0d, got %0d", e.stamp, stamp);
                fails++;
            end
            if (held !== e.held) begin
                $error("encoder_held: expected %0d, got %0d", e.held, held);
                fails++;
            end
            if (closes_poll !== e.closes_poll) begin
                $error("last_of_step: expected %0d, got %0d", e.closes_poll, closes_poll);
                fails++;
            end
        endfunction
    endclass

    logic i_clk;
    logic i_rst_n;

    bdcl_poll_if  poll_bus ();
    bdcl_cfg_if   cfg_bus ();
    bdcl_event_if event_bus ();

    button_debounce_click_long_press DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_poll  (poll_bus),
        .i_cfg   (cfg_bus),
        .o_event (event_bus)
    );

    key_event_scoreboard sb;
    int idle_pct;
    int stall_pct;
    int cycles;
    int polls_sent;
    int settings_used;

    initial begin
        i_clk = 1'b0;
    end

    always #(CLK_HALF) i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("button_debounce_click_long_press verification failed");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        event_bus.ready <= ($urandom_range(99) >= stall_pct);
    end

    always @(posedge i_clk) begin
        if (i_rst_n && event_bus.valid && event_bus.ready) begin
            sb.check_event(event_bus.event_code, event_bus.event_time_ms,
                           event_bus.encoder_held, event_bus.last_of_step);
        end
    end

    task automatic send_poll(input logic [31:0] now, input logic enc, input logic back);
        if (idle_pct > 0 && $urandom_range(99) < idle_pct) begin
            poll_bus.valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge i_clk);
        end
        poll_bus.valid            <= 1'b1;
        poll_bus.now_ms           <= now;
        poll_bus.encoder_key_down <= enc;
        poll_bus.back_key_down    <= back;
        do @(posedge i_clk); while (!poll_bus.ready);
        sb.note_poll(now, enc, back);
        polls_sent++;
    endtask

    // Polls that cause no event may still be in flight when the queue empties,
    // so the task keeps waiting after that before the block counts as idle.
    task automatic wait_until_quiet();
        poll_bus.valid <= 1'b0;
        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] val);
        cfg_bus.valid <= 1'b1;
        cfg_bus.index <= idx;
        cfg_bus.data  <= val;
        do @(posedge i_clk); while (!cfg_bus.ready);
        cfg_bus.valid <= 1'b0;
        sb.set_reg(idx, val);
        @(posedge i_clk);
    endtask

    initial begin
        int          deb_set[PHASES];
        int          lp_set[PHASES];
        int          deb;
        int          lp;
        int          step;
        logic [31:0] clock_ms;
        logic        enc_lvl;
        logic        back_lvl;

        sb = new();
        cycles        = 0;
        polls_sent    = 0;
        settings_used = 1;
        idle_pct      = 0;
        stall_pct     = 0;
        i_rst_n                   <= 1'b0;
        poll_bus.valid            <= 1'b0;
        poll_bus.now_ms           <= '0;
        poll_bus.encoder_key_down <= 1'b0;
        poll_bus.back_key_down    <= 1'b0;
        cfg_bus.valid             <= 1'b0;
        cfg_bus.index             <= '0;
        cfg_bus.data              <= '0;
        repeat (RESET_TICKS) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed part at the reset settings: exact debounce boundary, both keys
        // together, long press without click, and all four release events in one poll.
        send_poll(32'd0, 1'b0, 1'b0);
        send_poll(32'd10, 1'b1, 1'b0);
        send_poll(32'd39, 1'b1, 1'b0);
        send_poll(32'd40, 1'b1, 1'b0);
        send_poll(32'd100, 1'b0, 1'b1);
        send_poll(32'd130, 1'b0, 1'b1);
        send_poll(32'd200, 1'b1, 1'b1);
        send_poll(32'd230, 1'b1, 1'b0);
        send_poll(32'd260, 1'b1, 1'b0);
        send_poll(32'd829, 1'b1, 1'b0);
        send_poll(32'd830, 1'b1, 1'b0);
        send_poll(32'd900, 1'b0, 1'b1);
        send_poll(32'd930, 1'b0, 1'b1);
        send_poll(32'd1000, 1'b1, 1'b1);
        send_poll(32'd1030, 1'b1, 1'b1);
        send_poll(32'd1100, 1'b0, 1'b0);
        send_poll(32'd1130, 1'b0, 1'b0);
        // The timestamp wraps, then runs backwards.
        send_poll(32'hFFFF_FFF0, 1'b1, 1'b0);
        send_poll(32'h0000_000E, 1'b1, 1'b0);
        send_poll(32'h0000_0005, 1'b1, 1'b0);

        wait_until_quiet();
        write_reg(REG_UNUSED_LO, 16'h0007);
        write_reg(REG_UNUSED_HI, 16'hFFFF);
        write_reg(REG_DEBOUNCE, 16'd0);
        write_reg(REG_LONG_PRESS, 16'd0);
        settings_used++;
        send_poll(32'd50, 1'b0, 1'b0);
        send_poll(32'd60, 1'b1, 1'b1);
        send_poll(32'd61, 1'b0, 1'b0);

        wait_until_quiet();
        write_reg(REG_DEBOUNCE, 16'hFFFF);
        write_reg(REG_LONG_PRESS, 16'hFFFF);
        settings_used++;
        send_poll(32'd100, 1'b1, 1'b0);
        send_poll(32'd100 + 32'd65535, 1'b1, 1'b0);
        send_poll(32'd100 + 32'd131070, 1'b1, 1'b0);

        deb_set = '{30, 0, 65535, 1, 0, 12, $urandom_range(200), $urandom_range(65535)};
        lp_set  = '{600, 0, 65535, 50, 25, 0, $urandom_range(2000), $urandom_range(65535)};
        clock_ms = 32'd200000;
        enc_lvl  = 1'b1;
        back_lvl = 1'b0;
        for (int p = 0; p < PHASES; p++) begin
            wait_until_quiet();
            deb = deb_set[p];
            lp  = lp_set[p];
            write_reg(REG_DEBOUNCE, deb[15:0]);
            write_reg(REG_LONG_PRESS, lp[15:0]);
            settings_used++;
            case (p % 4)
                0: begin idle_pct = 0;  stall_pct = 0;  end
                1: begin idle_pct = 61; stall_pct = 0;  end
                2: begin idle_pct = 0;  stall_pct = 61; end
                default: begin idle_pct = 29; stall_pct = 29; end
            endcase
            for (int k = 0; k < PHASE_POLLS; k++) begin
                if ($urandom_range(99) < 2) begin
                    wait_until_quiet();
                end
                if ($urandom_range(99) < 82) begin
                    // Plausible key activity: bounces, debounce-length holds and long holds.
                    case ($urandom_range(3))
                        0: step = $urandom_range(3);
                        1: step = $urandom_range(deb * 2 + 1);
                        2: step = $urandom_range(lp + lp / 4 + 1);
                        default: step = deb;
                    endcase
                    clock_ms = clock_ms + step;
                    if ($urandom_range(99) < 25) enc_lvl = !enc_lvl;
                    if ($urandom_range(99) < 20) back_lvl = !back_lvl;
                end else begin
                    clock_ms = $urandom;
                    enc_lvl  = 1'($urandom_range(1));
                    back_lvl = 1'($urandom_range(1));
                end
                send_poll(clock_ms, enc_lvl, back_lvl);
            end
        end

        stall_pct = 0;
        wait_until_quiet();
        $display("Covered %0d polls under %0d register settings; %0d events compared in order.",
                 polls_sent, settings_used, sb.events_seen);
        $display("Idle patterns: none, sender gaps, receiver stalls and both at once.");
        if (sb.fails == 0 && sb.pending.size() == 0) begin
            $display("button_debounce_click_long_press verification clean");
        end else begin
            $display("button_debounce_click_long_press verification failed");
        end
        $finish;
    end

endmodule

[sim.f]
+incdir+design
design/bdcl_pkg.sv
design/bdcl_ifs.sv
design/bdcl_front.sv
design/bdcl_fifo.sv
design/bdcl_back.sv
design/button_debounce_click_long_press.sv
tb/sv/button_debounce_click_long_press_tb.sv
